// ===== rtl/scq_pkg.sv =====
// shared widths, register indexes and pipeline word types for scissor_clip_quad_uv
// no dependencies
package scq_pkg;

    localparam int CW = 16;              // output coordinate width
    localparam int IW = CW - 1;          // input coordinate and shift width
    localparam int UW = 17;              // UQ1.16 texture coordinate width
    localparam int DW = CW + 1;          // span / divisor width
    localparam int QW = UW;              // quotient width
    localparam int NW = UW + DW;         // product width
    localparam int LANES = 4;
    localparam int IDXW = 3;

    localparam logic [IDXW-1:0] REG_ENABLE = 3'd0;
    localparam logic [IDXW-1:0] REG_LEFT   = 3'd1;
    localparam logic [IDXW-1:0] REG_TOP    = 3'd2;
    localparam logic [IDXW-1:0] REG_RIGHT  = 3'd3;
    localparam logic [IDXW-1:0] REG_BOTTOM = 3'd4;
    localparam logic [IDXW-1:0] REG_SHX    = 3'd5;
    localparam logic [IDXW-1:0] REG_SHY    = 3'd6;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] low;   // dividend bits going out, quotient bits coming in
        logic [DW-1:0] d;
        logic          neg;
        logic [UW-1:0] t0;
    } t_div;

    typedef struct packed {
        logic [UW-1:0] mag;
        logic [DW-1:0] k;
        logic [DW-1:0] d;
        logic          neg;
        logic [UW-1:0] t0;
    } t_setup;

    typedef struct packed {
        logic                 vis;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } t_side;

endpackage

// ===== rtl/scq_div_cell.sv =====
// one restoring division step of the interpolation divider chain
// depends on scq_pkg
module scq_div_cell import scq_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_word,
    output t_div o_word
);

    t_div          r_word;
    t_div          n_word;
    logic [DW:0]   w_trial;
    logic          w_ge;

    always_comb begin
        w_trial = {i_word.rem, i_word.low[QW-1]};
        w_ge    = (w_trial >= {1'b0, i_word.d});
        n_word  = i_word;
        n_word.rem = w_ge ? DW'(w_trial - {1'b0, i_word.d}) : w_trial[DW-1:0];
        n_word.low = {i_word.low[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== rtl/scissor_clip_quad_uv.sv =====
// top level of the scissor clip with texture coordinate re-interpolation
// depends on scq_pkg and scq_div_cell
//
// a quad word is translated, clamped to the scissor rectangle and its four
// texture coordinates re-interpolated; one word is taken every cycle while the
// pipe advances. most of the pipe is the chain of seventeen divider cells, one
// quotient bit per cell, that each of the four interpolation lanes runs
// through. the whole pipe advances together and only holds while the output
// word is stalled. a rejected quad comes out with visible low and all other
// fields zero. configuration writes are always ready.
module scissor_clip_quad_uv import scq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDXW-1:0]      i_cfg_index,
    input  logic [CW-1:0]        i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [IW-1:0] i_corner_a_x,
    input  logic signed [IW-1:0] i_corner_a_y,
    input  logic signed [IW-1:0] i_corner_b_x,
    input  logic signed [IW-1:0] i_corner_b_y,
    input  logic [UW-1:0]        i_corner_a_u,
    input  logic [UW-1:0]        i_corner_a_v,
    input  logic [UW-1:0]        i_corner_b_u,
    input  logic [UW-1:0]        i_corner_b_v,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_visible,
    output logic signed [CW-1:0] o_out_a_x,
    output logic signed [CW-1:0] o_out_a_y,
    output logic signed [CW-1:0] o_out_b_x,
    output logic signed [CW-1:0] o_out_b_y,
    output logic [UW-1:0]        o_out_a_u,
    output logic [UW-1:0]        o_out_a_v,
    output logic [UW-1:0]        o_out_b_u,
    output logic [UW-1:0]        o_out_b_v
);

    localparam int NS = QW + 3;   // stages ahead of the output register

    // configuration registers
    logic                 r_en;
    logic signed [CW-1:0] r_cl, r_ct, r_cr, r_cb;
    logic signed [IW-1:0] r_shx, r_shy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_cl  <= '0;
            r_ct  <= '0;
            r_cr  <= '0;
            r_cb  <= '0;
            r_shx <= '0;
            r_shy <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_en  <= i_cfg_data[0];
                REG_LEFT:   r_cl  <= i_cfg_data;
                REG_TOP:    r_ct  <= i_cfg_data;
                REG_RIGHT:  r_cr  <= i_cfg_data;
                REG_BOTTOM: r_cb  <= i_cfg_data;
                REG_SHX:    r_shx <= i_cfg_data[IW-1:0];
                REG_SHY:    r_shy <= i_cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    // pipe control: everything moves unless the output word is held
    logic            w_adv;
    logic [NS-1:0]   r_vld;
    logic            r_out_vld;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NS-2:0], i_valid};
            r_out_vld <= r_vld[NS-1];
        end
    end

    // stage 1: translate
    logic signed [CW-1:0] r1_ax, r1_ay, r1_bx, r1_by;
    logic [UW-1:0]        r1_au, r1_av, r1_bu, r1_bv;
    logic                 r1_en;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ax <= CW'(signed'({i_corner_a_x[IW-1], i_corner_a_x}) +
                         signed'({r_shx[IW-1], r_shx}));
            r1_ay <= CW'(signed'({i_corner_a_y[IW-1], i_corner_a_y}) +
                         signed'({r_shy[IW-1], r_shy}));
            r1_bx <= CW'(signed'({i_corner_b_x[IW-1], i_corner_b_x}) +
                         signed'({r_shx[IW-1], r_shx}));
            r1_by <= CW'(signed'({i_corner_b_y[IW-1], i_corner_b_y}) +
                         signed'({r_shy[IW-1], r_shy}));
            r1_au <= i_corner_a_u;
            r1_av <= i_corner_a_v;
            r1_bu <= i_corner_b_u;
            r1_bv <= i_corner_b_v;
            r1_en <= r_en;
        end
    end

    // lane setup: numerator magnitude factors, divisor, sign and base value
    // zero span turns into dt * 1 / 2; scissor off forces dt to zero
    function automatic t_setup lane_setup(input logic [DW-1:0] k,
                                          input logic [DW-1:0] span,
                                          input logic [UW-1:0] t0,
                                          input logic [UW-1:0] t1,
                                          input logic [UW-1:0] tpass,
                                          input logic          en);
        t_setup        s;
        logic [UW:0]   dt;
        dt     = en ? ({1'b0, t1} - {1'b0, t0}) : '0;
        s.neg  = dt[UW];
        s.mag  = dt[UW] ? UW'(-dt) : dt[UW-1:0];
        s.t0   = en ? t0 : tpass;
        if (span == '0) begin
            s.k = DW'(1);
            s.d = DW'(2);
        end else begin
            s.k = k;
            s.d = span;
        end
        return s;
    endfunction

    // stage 2: clamp, reject test and lane setup
    logic signed [CW-1:0] w_ux, w_lx, w_uy, w_ly;
    logic [DW-1:0]        w_spx, w_spy;
    logic                 w_vis;
    t_side                n2_side;
    t_setup               n2_lane [LANES];
    t_side                r2_side;
    t_setup               r2_lane [LANES];

    always_comb begin
        w_ux  = (r_cl > r1_ax)  ? r_cl : r1_ax;
        w_lx  = (r_cr <= r1_bx) ? r_cr : r1_bx;
        w_uy  = (r_ct > r1_ay)  ? r_ct : r1_ay;
        w_ly  = (r_cb <= r1_by) ? r_cb : r1_by;
        w_spx = {r1_bx[CW-1], r1_bx} - {r1_ax[CW-1], r1_ax};
        w_spy = {r1_by[CW-1], r1_by} - {r1_ay[CW-1], r1_ay};
        w_vis = !r1_en || ((w_ux <= w_lx) && (w_uy <= w_ly));
        n2_side.vis = w_vis;
        n2_side.ax  = r1_en ? w_ux : r1_ax;
        n2_side.ay  = r1_en ? w_uy : r1_ay;
        n2_side.bx  = r1_en ? w_lx : r1_bx;
        n2_side.by  = r1_en ? w_ly : r1_by;
        n2_lane[0] = lane_setup({w_ux[CW-1], w_ux} - {r1_ax[CW-1], r1_ax}, w_spx,
                                r1_au, r1_bu, r1_au, r1_en);
        n2_lane[1] = lane_setup({w_uy[CW-1], w_uy} - {r1_ay[CW-1], r1_ay}, w_spy,
                                r1_av, r1_bv, r1_av, r1_en);
        n2_lane[2] = lane_setup({w_lx[CW-1], w_lx} - {r1_ax[CW-1], r1_ax}, w_spx,
                                r1_au, r1_bu, r1_bu, r1_en);
        n2_lane[3] = lane_setup({w_ly[CW-1], w_ly} - {r1_ay[CW-1], r1_ay}, w_spy,
                                r1_av, r1_bv, r1_bv, r1_en);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_side <= n2_side;
            r2_lane <= n2_lane;
        end
    end

    // stage 3: one multiply per lane, split into divider seed
    t_div  r3_div [LANES];
    t_side r3_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_side <= r2_side;
            for (int l = 0; l < LANES; l++) begin
                logic [NW-1:0] prod;
                prod = NW'(r2_lane[l].mag) * NW'(r2_lane[l].k);
                r3_div[l].rem <= prod[NW-1:QW];
                r3_div[l].low <= prod[QW-1:0];
                r3_div[l].d   <= r2_lane[l].d;
                r3_div[l].neg <= r2_lane[l].neg;
                r3_div[l].t0  <= r2_lane[l].t0;
            end
        end
    end

    // divider chain, one quotient bit per cell
    t_div  w_chain [QW+1][LANES];
    t_side r_side  [QW];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_chain[0][l] = r3_div[l];
        for (genvar s = 0; s < QW; s++) begin : g_cell
            scq_div_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_word (w_chain[s][l]),
                .o_word (w_chain[s+1][l])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r3_side;
            for (int s = 1; s < QW; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // output stage: floor correction for negative slopes, add base, mask rejects
    logic [UW-1:0] n_uv [LANES];
    logic [UW-1:0] r_uv [LANES];
    t_side         r_oside;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [UW:0] q;
            logic [UW:0] res;
            q   = {1'b0, w_chain[QW][l].low};
            if (w_chain[QW][l].neg) begin
                res = {1'b0, w_chain[QW][l].t0} - q -
                      (UW+1)'(w_chain[QW][l].rem != '0);
            end else begin
                res = {1'b0, w_chain[QW][l].t0} + q;
            end
            n_uv[l] = r_side[QW-1].vis ? res[UW-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_uv        <= n_uv;
            r_oside.vis <= r_side[QW-1].vis;
            r_oside.ax  <= r_side[QW-1].vis ? r_side[QW-1].ax : '0;
            r_oside.ay  <= r_side[QW-1].vis ? r_side[QW-1].ay : '0;
            r_oside.bx  <= r_side[QW-1].vis ? r_side[QW-1].bx : '0;
            r_oside.by  <= r_side[QW-1].vis ? r_side[QW-1].by : '0;
        end
    end

    assign o_visible = r_oside.vis;
    assign o_out_a_x = r_oside.ax;
    assign o_out_a_y = r_oside.ay;
    assign o_out_b_x = r_oside.bx;
    assign o_out_b_y = r_oside.by;
    assign o_out_a_u = r_uv[0];
    assign o_out_a_v = r_uv[1];
    assign o_out_b_u = r_uv[2];
    assign o_out_b_v = r_uv[3];

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for scissor_clip_quad_uv
// drives quad words through translate and scissor settings and compares each result
// word with a behavioral prediction; depends on scq_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import scq_pkg::*;

    // one quad and one clipped quad, at the block's widths
    typedef struct {
        logic signed [IW-1:0] ax, ay, bx, by;
        logic [UW-1:0]        au, av, bu, bv;
    } t_quad;

    typedef struct {
        logic                 vis;
        logic signed [CW-1:0] ax, ay, bx, by;
        logic [UW-1:0]        au, av, bu, bv;
    } t_clipped;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDXW-1:0]      i_cfg_index = '0;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [IW-1:0] i_corner_a_x = '0, i_corner_a_y = '0;
    logic signed [IW-1:0] i_corner_b_x = '0, i_corner_b_y = '0;
    logic [UW-1:0]        i_corner_a_u = '0, i_corner_a_v = '0;
    logic [UW-1:0]        i_corner_b_u = '0, i_corner_b_v = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_visible;
    logic signed [CW-1:0] o_out_a_x, o_out_a_y, o_out_b_x, o_out_b_y;
    logic [UW-1:0]        o_out_a_u, o_out_a_v, o_out_b_u, o_out_b_v;

    scissor_clip_quad_uv i_dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow copy of the scissor registers
    logic                 scissor_on;
    logic signed [CW-1:0] edge_l, edge_t, edge_r, edge_b;
    logic signed [IW-1:0] offs_x, offs_y;

    t_clipped pending_quads[$];
    int       send_idle_pct;      // chance per cycle that the sender holds off
    int       recv_stall_pct;     // chance per cycle that the receiver stalls
    int       mismatches;
    int       words_checked;
    int       quads_sent;
    int       visible_seen;
    int       quiet_cycles;

    // texture coordinate along one axis between translated ends p0 and p1
    function automatic logic [UW-1:0] lerp_uv(longint p, longint p0, longint p1,
                                              longint t0, longint t1);
        longint num, den, q;
        if (p0 == p1) begin
            num = t1 - t0;
            den = 2;
        end else begin
            num = (t1 - t0) * (p - p0);
            den = p1 - p0;
        end
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        q = num / den;
        if (num % den != 0 && num < 0) q = q - 1;
        return UW'(t0 + q);
    endfunction

    function automatic t_clipped clip_quad(t_quad q);
        t_clipped r;
        longint   ax, ay, bx, by, ux, lx, uy, ly;
        ax = longint'(q.ax) + longint'(offs_x);
        ay = longint'(q.ay) + longint'(offs_y);
        bx = longint'(q.bx) + longint'(offs_x);
        by = longint'(q.by) + longint'(offs_y);
        r.vis = 1'b1;
        r.ax = CW'(ax); r.ay = CW'(ay); r.bx = CW'(bx); r.by = CW'(by);
        r.au = q.au; r.av = q.av; r.bu = q.bu; r.bv = q.bv;
        if (scissor_on) begin
            ux = (edge_l > ax) ? edge_l : ax;
            lx = (edge_r <= bx) ? edge_r : bx;
            uy = (edge_t > ay) ? edge_t : ay;
            ly = (edge_b <= by) ? edge_b : by;
            if (ux > lx || uy > ly) begin
                r = '{default: '0};
            end else begin
                r.ax = CW'(ux); r.ay = CW'(uy); r.bx = CW'(lx); r.by = CW'(ly);
                r.au = lerp_uv(ux, ax, bx, q.au, q.bu);
                r.bu = lerp_uv(lx, ax, bx, q.au, q.bu);
                r.av = lerp_uv(uy, ay, by, q.av, q.bv);
                r.bv = lerp_uv(ly, ay, by, q.av, q.bv);
            end
        end
        return r;
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_clipped e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_checked++;
            if (o_visible) visible_seen++;
            if (pending_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                e = pending_quads.pop_front();
                if (o_visible !== e.vis || o_out_a_x !== e.ax || o_out_a_y !== e.ay ||
                    o_out_b_x !== e.bx || o_out_b_y !== e.by || o_out_a_u !== e.au ||
                    o_out_a_v !== e.av || o_out_b_u !== e.bu || o_out_b_v !== e.bv) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp vis %0d a (%0d,%0d) b (%0d,%0d) uv %0d %0d %0d %0d",
                                 e.vis, e.ax, e.ay, e.bx, e.by, e.au, e.av, e.bu, e.bv);
                        $display("  got vis %0d a (%0d,%0d) b (%0d,%0d) uv %0d %0d %0d %0d",
                                 o_visible, o_out_a_x, o_out_a_y, o_out_b_x, o_out_b_y,
                                 o_out_a_u, o_out_a_v, o_out_b_u, o_out_b_v);
                    end
                end
            end
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays up across back-to-back writes; set_scissor drops it at the end
    task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ENABLE: scissor_on = val[0];
            REG_LEFT:   edge_l = val;
            REG_TOP:    edge_t = val;
            REG_RIGHT:  edge_r = val;
            REG_BOTTOM: edge_b = val;
            REG_SHX:    offs_x = val[IW-1:0];
            REG_SHY:    offs_y = val[IW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_scissor(logic en, int l, int t, int r, int b, int sx, int sy);
        write_reg(REG_ENABLE, CW'(en));
        write_reg(REG_LEFT, CW'(l));
        write_reg(REG_TOP, CW'(t));
        write_reg(REG_RIGHT, CW'(r));
        write_reg(REG_BOTTOM, CW'(b));
        write_reg(REG_SHX, CW'(sx));
        write_reg(REG_SHY, CW'(sy));
        i_cfg_valid <= 1'b0;
    endtask

    // wait for the pipe to empty before touching the registers
    task automatic drain();
        int n;
        n = 0;
        i_valid <= 1'b0;
        while (pending_quads.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (QW + 10) @(posedge i_clk);
    endtask

    // valid stays up between back-to-back words, dropped only in idle cycles
    task automatic send_quad(t_quad q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_corner_a_x <= q.ax; i_corner_a_y <= q.ay;
        i_corner_b_x <= q.bx; i_corner_b_y <= q.by;
        i_corner_a_u <= q.au; i_corner_a_v <= q.av;
        i_corner_b_u <= q.bu; i_corner_b_v <= q.bv;
        do @(posedge i_clk); while (o_stall);
        pending_quads = {pending_quads, clip_quad(q)};
        quads_sent++;
    endtask

    function automatic logic [UW-1:0] rand_uv();
        case ($urandom_range(5))
            0: return '0;
            1: return 17'd65536;
            2: return 17'h1ffff;    // outside the nominal range, still legal bits
            default: return UW'($urandom_range(65536));
        endcase
    endfunction

    // quads mostly around the scissor window so clipping actually bites
    function automatic t_quad rand_quad();
        t_quad q;
        int    x0, y0;
        if ($urandom_range(9) < 2) begin
            q.ax = IW'($urandom); q.ay = IW'($urandom);
            q.bx = IW'($urandom); q.by = IW'($urandom);
        end else begin
            x0 = $urandom_range(600) - 300;
            y0 = $urandom_range(600) - 300;
            q.ax = IW'(x0); q.ay = IW'(y0);
            q.bx = IW'(x0 + $urandom_range(400) - 20);
            q.by = IW'(y0 + $urandom_range(400) - 20);
        end
        q.au = rand_uv(); q.av = rand_uv(); q.bu = rand_uv(); q.bv = rand_uv();
        return q;
    endfunction

    task automatic test_passthrough();
        set_scissor(1'b0, 0, 0, 0, 0, 16383, -16384);
        send_quad('{-16384, -16384, 16383, 16383, 0, 65536, 65536, 0});
        send_quad('{16383, 16383, -16384, -16384, 17'h1ffff, 1, 2, 3});
        drain();
    endtask

    task automatic test_directed_clip();
        set_scissor(1'b1, -100, -50, 100, 50, 10, -10);
        send_quad('{-200, -100, 200, 100, 0, 0, 65536, 65536});     // clipped on all sides
        send_quad('{-5, -5, 5, 5, 100, 200, 300, 400});             // fully inside
        send_quad('{7, 7, 7, 7, 0, 65536, 65536, 0});               // zero span, halving
        send_quad('{50, 0, -50, 20, 0, 0, 0, 0});                   // inverted, rejected
        send_quad('{500, 0, 600, 10, 1, 1, 1, 1});                  // outside, rejected
        send_quad('{90, 60, 200, 90, 0, 0, 65536, 65536});          // touching right edge
        send_quad('{-110, -40, 0, 0, 65536, 65536, 0, 0});          // touching left edge
        send_quad('{-16384, -16384, 16383, 16383, 17'h1ffff, 0, 0, 17'h1ffff});
        drain();
        set_scissor(1'b1, -32768, -32768, 32767, 32767, -16384, 16383);
        send_quad('{-16384, -16384, 16383, 16383, 0, 65536, 65536, 0});
        send_quad('{16383, 0, 16383, 0, 3, 5, 65536, 1});
        drain();
        set_scissor(1'b1, 32767, 32767, -32768, -32768, 0, 0);      // empty window
        send_quad('{0, 0, 10, 10, 0, 0, 0, 0});
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        set_scissor($urandom_range(3) != 0, $urandom_range(400) - 300,
                    $urandom_range(400) - 300, $urandom_range(400) - 100,
                    $urandom_range(400) - 100, $urandom_range(200) - 100,
                    $urandom_range(200) - 100);
        repeat (count) send_quad(rand_quad());
        drain();
    endtask

    initial begin
        quiet_cycles = 0;
        mismatches = 0;
        words_checked = 0;
        quads_sent = 0;
        visible_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        scissor_on = 1'b0;
        edge_l = '0; edge_t = '0; edge_r = '0; edge_b = '0;
        offs_x = '0; offs_y = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_directed_clip();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: test_random(50, 0, 0);
                1: test_random(50, 73, 0);
                2: test_random(50, 0, 73);
                default: test_random(50, 32, 32);
            endcase
        end

        $display("sent %0d quads, checked %0d words, %0d visible, across pass-through",
                 quads_sent, words_checked, visible_seen);
        $display("and clipped settings with sender gaps and receiver stalls");
        if (mismatches == 0 && pending_quads.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scq_pkg.sv
rtl/scq_div_cell.sv
rtl/scissor_clip_quad_uv.sv
tb/tb.sv
